[rtl/readout_event_decoder_macros.svh]
// assertion macros for the readout event decoder
// each macro expects clk_i and rst_ni in scope
`ifndef READOUT_EVENT_DECODER_MACROS_SVH
`define READOUT_EVENT_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define RDEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define RDEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define RDEC_ASSERT_NOW(lbl, ante, cons)
`define RDEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/rdec_pkg.sv]
package rdec_pkg;

  // number of bytes held before the closing byte of an event
  localparam int unsigned StoredBytes = 5;

  // channel map constants
  localparam logic [1:0] T0Group   = 2'd3;
  localparam logic [3:0] T0Chan    = 4'd15;
  localparam logic [5:0] T0Number  = 6'd36;
  localparam logic [3:0] ChansPerGroup = 4'd9;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FINE_OFFSET   = 1'b0,
    REG_MEDIUM_OFFSET = 1'b1
  } rdec_reg_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  // raw six-byte event as assembled by the front end
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } rdec_event_t;

  // configured offsets
  typedef struct packed {
    logic [4:0] fine_offset;
    logic [2:0] medium_offset;
  } rdec_cfg_t;

  // queue status seen by the front end, the back end and the checks
  typedef struct packed {
    logic full;
    logic empty;
  } rdec_qstat_t;

  // decoded record
  typedef struct packed {
    logic [5:0]  channel_number;
    logic        channel_valid;
    logic        gain_select;
    logic [9:0]  adc_high_res;
    logic [5:0]  adc_low_res;
    logic [7:0]  adc_pipeline;
    logic [18:0] coarse_count;
    logic [2:0]  medium_count;
    logic [4:0]  fine_count;
    logic [24:0] timestamp;
  } rdec_result_t;

  // fixed remap of the medium count
  function automatic logic [2:0] medium_map(input logic [2:0] code);
    logic [2:0] m;
    case (code)
      3'd0:    m = 3'd6;
      3'd1:    m = 3'd1;
      3'd2:    m = 3'd2;
      3'd3:    m = 3'd5;
      3'd4:    m = 3'd4;
      3'd5:    m = 3'd3;
      3'd6:    m = 3'd0;
      3'd7:    m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

[rtl/rdec_front.sv]
module rdec_front
  import rdec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  event_byte_i,
  input  rdec_qstat_t qstat_i,
  output logic        push_o,
  output rdec_event_t event_o,
  output logic [2:0]  pos_o
);

  logic [2:0] pos_q, pos_d;
  logic [7:0] store_q [StoredBytes];
  logic       accept;
  logic       last_byte;

  // hold the link only while the queue has no room
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i & ~qstat_i.full;
  assign last_byte  = (pos_q >= 3'(StoredBytes));
  assign push_o     = accept & last_byte;
  assign pos_o      = pos_q;

  // byte position within the event
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last_byte ? 3'd0 : pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // store the leading bytes
  always_ff @(posedge clk_i) begin
    if (accept && !last_byte) begin
      store_q[pos_q] <= event_byte_i;
    end
  end

  // complete event, closing byte taken straight from the link
  assign event_o = '{
    b0: store_q[0],
    b1: store_q[1],
    b2: store_q[2],
    b3: store_q[3],
    b4: store_q[4],
    b5: event_byte_i
  };

endmodule

[rtl/rdec_queue.sv]
module rdec_queue
  import rdec_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rdec_event_t push_data_i,
  input  logic        pop_i,
  output rdec_event_t pop_data_o,
  output rdec_qstat_t qstat_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  rdec_event_t       mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == CountW'(Depth));
  assign qstat_o.empty = (count_q == '0);
  assign pop_data_o    = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/rdec_back.sv]
module rdec_back
  import rdec_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rdec_cfg_t    cfg_i,
  input  logic         q_valid_i,
  input  rdec_event_t  q_data_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output rdec_result_t result_o
);

  logic         out_valid_q, out_valid_d;
  rdec_result_t result_q, res;

  logic [1:0]  grp;
  logic [3:0]  chan;
  logic [4:0]  fc;
  logic [2:0]  mc;
  logic [1:0]  ma;
  logic [17:0] ca;

  // take a new event when the output register is free or draining
  assign pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  // field unpack and decode
  always_comb begin
    grp  = q_data_i.b0[7:6];
    chan = q_data_i.b0[5:2];

    res.gain_select  = q_data_i.b0[1];
    res.adc_high_res = ~{q_data_i.b0[0], q_data_i.b1, q_data_i.b2[7]};
    res.adc_low_res  = ~{q_data_i.b0[0], q_data_i.b1[7:3]};
    res.adc_pipeline = ~{q_data_i.b1[2:0], q_data_i.b2[7:3]};
    res.coarse_count = {q_data_i.b2[2:0], q_data_i.b3, q_data_i.b4};
    res.medium_count = medium_map(q_data_i.b5[7:5]);
    res.fine_count   = ~q_data_i.b5[4:0];

    // channel map, T0 has a number of its own
    if (grp == T0Group && chan == T0Chan) begin
      res.channel_number = T0Number;
      res.channel_valid  = 1'b1;
    end else if (chan < ChansPerGroup) begin
      res.channel_number = {1'b0, grp, 3'b000} + {4'b0000, grp} + {2'b00, chan};
      res.channel_valid  = 1'b1;
    end else begin
      res.channel_number = 6'd0;
      res.channel_valid  = 1'b0;
    end

    // offsets and medium/coarse alignment
    fc = res.fine_count + cfg_i.fine_offset;
    mc = res.medium_count + cfg_i.medium_offset;
    ma = mc[2:1];
    if (mc[0] && fc[4:3] == 2'd0) begin
      ma = mc[2:1] + 2'd1;
    end else if (!mc[0] && fc[4:3] == 2'd3) begin
      ma = mc[2:1] - 2'd1;
    end
    ca = res.coarse_count[18:1];
    if (res.coarse_count[0] && ma == 2'd0) begin
      ca = ca + 18'd1;
    end else if (!res.coarse_count[0] && ma == 2'd3) begin
      ca = ca - 18'd1;
    end
    res.timestamp = {ca, ma, fc};
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[rtl/readout_event_decoder.sv]
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  event_byte_i (one byte per beat)
// out       output     out_valid_o/out_stall_i decoded record fields
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte beat per cycle while in_stall_o is low; every sixth byte yields
// one record beat. a record enters the event queue when its closing byte
// is taken and passes on to the output register, which then holds it.
// reset clears the byte position, the queue and the output valid, and sets
// fine_offset to 0 and medium_offset to 1.
// in_stall_o rises only when the event queue (QueueDepth entries) is full.
`include "readout_event_decoder_macros.svh"

module readout_event_decoder
  import rdec_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          event_byte_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          channel_number_o,
  output logic                channel_valid_o,
  output logic                gain_select_o,
  output logic [9:0]          adc_high_res_o,
  output logic [5:0]          adc_low_res_o,
  output logic [7:0]          adc_pipeline_o,
  output logic [18:0]         coarse_count_o,
  output logic [2:0]          medium_count_o,
  output logic [4:0]          fine_count_o,
  output logic [24:0]         timestamp_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  rdec_cfg_t    cfg_q, cfg_d;
  rdec_qstat_t  qstat;
  rdec_event_t  push_data, pop_data;
  rdec_result_t result;
  logic         push, pop;
  logic [2:0]   pos;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (rdec_reg_e'(cfg_index_i))
        REG_FINE_OFFSET:   cfg_d.fine_offset   = cfg_data_i[4:0];
        REG_MEDIUM_OFFSET: cfg_d.medium_offset = cfg_data_i[2:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fine_offset: 5'd0, medium_offset: 3'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // byte assembly
  rdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .event_byte_i(event_byte_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .event_o     (push_data),
    .pos_o       (pos)
  );

  // event queue between assembly and decode
  rdec_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .qstat_o    (qstat)
  );

  // decode and time alignment
  rdec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (~qstat.empty),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result)
  );

  assign channel_number_o = result.channel_number;
  assign channel_valid_o  = result.channel_valid;
  assign gain_select_o    = result.gain_select;
  assign adc_high_res_o   = result.adc_high_res;
  assign adc_low_res_o    = result.adc_low_res;
  assign adc_pipeline_o   = result.adc_pipeline;
  assign coarse_count_o   = result.coarse_count;
  assign medium_count_o   = result.medium_count;
  assign fine_count_o     = result.fine_count;
  assign timestamp_o      = result.timestamp;

  // checks
  `RDEC_ASSERT_NOW(a_pos_range, 1'b1, pos <= 3'(StoredBytes))
  `RDEC_ASSERT_NOW(a_no_overflow, push, !qstat.full || pop)
  `RDEC_ASSERT_NEXT(a_push_lands, push, !qstat.empty)
  `RDEC_ASSERT_NOW(a_out_from_pop, $rose(out_valid_o), $past(pop))

endmodule
